// ----- design/urn_random_draw_with_hold_unit_macros.svh -----
// Assertion helpers; the enclosing module provides clk and arst_n.
`ifndef URN_RANDOM_DRAW_WITH_HOLD_UNIT_MACROS_SVH
`define URN_RANDOM_DRAW_WITH_HOLD_UNIT_MACROS_SVH

// same-cycle implication
`define URN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("urn assertion failed");

// next-cycle implication
`define URN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("urn assertion failed");

`endif

// ----- design/urn_pkg.sv -----
`timescale 1ns / 1ps
package urn_pkg;

	localparam int DEF_MAX_SIZE = 256;
	localparam int DEF_MAX_HOLD = 128;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int SIZE_FIELD_W = 9;
	localparam int HOLD_FIELD_W = 8;
	localparam int DATA_W       = 32;

	localparam int RST_SET_SIZE = 2;

	localparam logic OP_DRAW  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		REG_SET_SIZE   = 2'd0,
		REG_OFFSET     = 2'd1,
		REG_HOLD_COUNT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic cnt_step;
		logic mul;
		logic find_step;
		logic mark;
		logic refill_step;
	} cmd_t;

	typedef struct packed {
		logic op_clear;
		logic scan_end;
		logic cnt_zero;
		logic hit;
		logic out_free;
		logic eos;
		logic hold_zero;
		logic refill_done;
	} sts_t;

endpackage

// ----- design/urn_if.sv -----
`timescale 1ns / 1ps
interface urn_req_if;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [31:0]       rand_fraction;

	modport source (output valid, output opcode, output rand_fraction, input ready);
	modport sink (input valid, input opcode, input rand_fraction, output ready);
endinterface

interface urn_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] drawn_value;
	logic              end_of_set;

	modport source (output valid, output drawn_value, output end_of_set, input ready);
	modport sink (input valid, input drawn_value, input end_of_set, output ready);
endinterface

// ----- design/urn_random_draw_with_hold_unit.sv -----
`timescale 1ns / 1ps
// Port   Dir  Beat contents
// req    in   opcode, rand_fraction
// rsp    out  drawn_value, end_of_set
// apb    in   set_size, offset, hold_count (byte address 4*i)
//
// Draw: the used bits are walked one per cycle, once to count free indices and once
// to locate the k-th. At end of set the used bits are cleared and the held picks are
// re-marked from the history RAM. No clearing pass after reset; req is ready at once.
// A new beat is accepted while a result waits in the rsp register; the next result
// holds in its mark step until that register is taken.
module urn_random_draw_with_hold_unit #(
	parameter int MAX_SIZE = urn_pkg::DEF_MAX_SIZE,
	parameter int MAX_HOLD = urn_pkg::DEF_MAX_HOLD
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [urn_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [urn_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [urn_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	urn_req_if.sink                         req,
	urn_rsp_if.source                       rsp
);
	import urn_pkg::*;

	localparam int SZW = $clog2(MAX_SIZE+1);
	localparam int HW  = $clog2(MAX_HOLD+1);

	logic [SZW-1:0]    set_size;
	logic [DATA_W-1:0] offset;
	logic [HW-1:0]     hold_count;
	logic              cfg_wipe;
	cmd_t              cmd;
	sts_t              sts;

	urn_regs #(
		.MAX_SIZE(MAX_SIZE),
		.MAX_HOLD(MAX_HOLD)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.set_size  (set_size),
		.offset    (offset),
		.hold_count(hold_count),
		.cfg_wipe  (cfg_wipe)
	);

	urn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	urn_dp #(
		.MAX_SIZE(MAX_SIZE),
		.MAX_HOLD(MAX_HOLD)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_opcode (req.opcode),
		.req_rand   (req.rand_fraction),
		.set_size   (set_size),
		.offset     (offset),
		.hold_count (hold_count),
		.cfg_wipe   (cfg_wipe),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.drawn_value(rsp.drawn_value),
		.end_of_set (rsp.end_of_set)
	);

endmodule

// ----- design/urn_regs.sv -----
`timescale 1ns / 1ps
module urn_regs #(
	parameter int MAX_SIZE = urn_pkg::DEF_MAX_SIZE,
	parameter int MAX_HOLD = urn_pkg::DEF_MAX_HOLD
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [urn_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [urn_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [urn_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output logic [$clog2(MAX_SIZE+1)-1:0]       set_size,
	output logic [urn_pkg::DATA_W-1:0]          offset,
	output logic [$clog2(MAX_HOLD+1)-1:0]       hold_count,
	output logic                                cfg_wipe
);
	import urn_pkg::*;

	localparam int SZW = $clog2(MAX_SIZE+1);
	localparam int HW  = $clog2(MAX_HOLD+1);

	logic [SZW-1:0]    size_q;
	logic [DATA_W-1:0] offset_q;
	logic [HW-1:0]     hold_q;
	logic              wr_en;
	logic [1:0]        reg_idx;
	logic [31:0]       n32, nl32, cl32, h32;
	logic [SZW-1:0]    size_d;
	logic [HW-1:0]     hold_d;
	logic              size_chg, hold_chg;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign pready  = 1'b1;

	always_comb begin
		n32 = 32'(pwdata[SIZE_FIELD_W-1:0]);
		if (n32 == 32'd0) begin
			n32 = 32'd1;
		end
		if (n32 > 32'(MAX_SIZE)) begin
			n32 = 32'(MAX_SIZE);
		end
		nl32 = n32 >> 1;
		if (nl32 > 32'(MAX_HOLD)) begin
			nl32 = 32'(MAX_HOLD);
		end
		cl32 = 32'(size_q) >> 1;
		if (cl32 > 32'(MAX_HOLD)) begin
			cl32 = 32'(MAX_HOLD);
		end
		h32 = 32'(pwdata[HOLD_FIELD_W-1:0]);
		if (h32 > cl32) begin
			h32 = cl32;
		end
		size_d = n32[SZW-1:0];
		hold_d = h32[HW-1:0];
	end

	assign size_chg = wr_en && (reg_idx == REG_SET_SIZE) && (size_d != size_q);
	assign hold_chg = wr_en && (reg_idx == REG_HOLD_COUNT) && (hold_d != hold_q);
	assign cfg_wipe = size_chg || hold_chg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SZW'(RST_SET_SIZE);
			offset_q <= '0;
			hold_q   <= '0;
		end else begin
			if (size_chg) begin
				size_q <= size_d;
				if (32'(hold_q) > nl32) begin
					hold_q <= nl32[HW-1:0];
				end
			end
			if (wr_en && reg_idx == REG_OFFSET) begin
				offset_q <= pwdata[DATA_W-1:0];
			end
			if (hold_chg) begin
				hold_q <= hold_d;
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SET_SIZE:   prdata = APB_DATA_W'(size_q);
			REG_OFFSET:     prdata = APB_DATA_W'(offset_q);
			REG_HOLD_COUNT: prdata = APB_DATA_W'(hold_q);
			default:        prdata = '0;
		endcase
	end

	assign set_size   = size_q;
	assign offset     = offset_q;
	assign hold_count = hold_q;

endmodule

// ----- design/urn_ctrl.sv -----
`timescale 1ns / 1ps
module urn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  urn_pkg::sts_t sts,
	output urn_pkg::cmd_t cmd
);
	import urn_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_COUNT  = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_FIND   = 6'b001000,
		ST_MARK   = 6'b010000,
		ST_REFILL = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.op_clear) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_COUNT;
					end
				end
			end
			ST_COUNT: begin
				if (sts.scan_end) begin
					state_d = sts.cnt_zero ? ST_IDLE : ST_MUL;
				end else begin
					cmd.cnt_step = 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIND;
			end
			ST_FIND: begin
				cmd.find_step = 1'b1;
				if (sts.hit) begin
					state_d = ST_MARK;
				end else if (sts.scan_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_MARK: begin
				if (sts.out_free) begin
					cmd.mark = 1'b1;
					state_d  = (sts.eos && !sts.hold_zero) ? ST_REFILL : ST_IDLE;
				end
			end
			ST_REFILL: begin
				cmd.refill_step = 1'b1;
				if (sts.refill_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/urn_dp.sv -----
`timescale 1ns / 1ps
`include "urn_random_draw_with_hold_unit_macros.svh"
module urn_dp #(
	parameter int MAX_SIZE = urn_pkg::DEF_MAX_SIZE,
	parameter int MAX_HOLD = urn_pkg::DEF_MAX_HOLD
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  urn_pkg::cmd_t                   cmd,
	output urn_pkg::sts_t                   sts,
	input  logic                            req_opcode,
	input  logic [urn_pkg::DATA_W-1:0]      req_rand,
	input  logic [$clog2(MAX_SIZE+1)-1:0]   set_size,
	input  logic [urn_pkg::DATA_W-1:0]      offset,
	input  logic [$clog2(MAX_HOLD+1)-1:0]   hold_count,
	input  logic                            cfg_wipe,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic signed [urn_pkg::DATA_W-1:0] drawn_value,
	output logic                            end_of_set
);
	import urn_pkg::*;

	localparam int SZW = $clog2(MAX_SIZE+1);
	localparam int IW  = $clog2(MAX_SIZE);
	localparam int HW  = $clog2(MAX_HOLD+1);
	localparam int HIW = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;
	localparam int PW  = DATA_W + SZW;

	logic [MAX_SIZE-1:0] used_q;
	logic [IW-1:0]       hist_mem [MAX_HOLD];

	logic [SZW-1:0]    idx_q, cnt_q, k_q, seen_q;
	logic [DATA_W-1:0] rand_q;
	logic [IW-1:0]     pick_q;
	logic [HIW-1:0]    wptr_q;
	logic [HW-1:0]     fill_q, rptr_q;
	logic [IW-1:0]     rd_s1;
	logic              rd_vld_s1, rd_use_s1;
	logic              out_vld_q, out_eos_q;
	logic [DATA_W-1:0] out_val_q;

	logic              cur_free, scan_end, hit, eos, hold_zero, wipe_hist;
	logic [PW-1:0]     prod;
	logic [SZW-1:0]    k_raw;
	logic [HW-1:0]     hold_m1;

	assign scan_end  = (idx_q >= set_size);
	assign cur_free  = !used_q[idx_q[IW-1:0]];
	assign hit       = !scan_end && cur_free && (seen_q == k_q);
	assign eos       = (cnt_q == SZW'(1));
	assign hold_zero = (hold_count == '0);
	assign hold_m1   = hold_count - HW'(1);
	assign wipe_hist = cfg_wipe || cmd.clear;

	assign prod  = PW'(rand_q) * PW'(cnt_q);
	assign k_raw = prod[PW-1:DATA_W];

	assign sts.op_clear    = (req_opcode == OP_CLEAR);
	assign sts.scan_end    = scan_end;
	assign sts.cnt_zero    = (cnt_q == '0);
	assign sts.hit         = hit;
	assign sts.out_free    = !out_vld_q || rsp_ready;
	assign sts.eos         = eos;
	assign sts.hold_zero   = hold_zero;
	assign sts.refill_done = (rptr_q >= hold_count) && !rd_vld_s1;

	// scan counters and draw operands
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rand_q <= req_rand;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.cnt_step) begin
			if (cur_free) begin
				cnt_q <= cnt_q + SZW'(1);
			end
			idx_q <= idx_q + SZW'(1);
		end else if (cmd.mul) begin
			k_q    <= (k_raw >= cnt_q) ? cnt_q - SZW'(1) : k_raw;
			idx_q  <= '0;
			seen_q <= '0;
		end else if (cmd.find_step && !scan_end) begin
			if (hit) begin
				pick_q <= idx_q[IW-1:0];
			end else if (cur_free) begin
				seen_q <= seen_q + SZW'(1);
			end
			idx_q <= idx_q + SZW'(1);
		end
	end

	// used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wipe_hist || (cmd.mark && eos)) begin
			used_q <= '0;
		end else if (cmd.mark) begin
			used_q[pick_q] <= 1'b1;
		end else if (cmd.refill_step && rd_vld_s1) begin
			used_q[rd_use_s1 ? rd_s1 : IW'(0)] <= 1'b1;
		end
	end

	// hold history ring
	always_ff @(posedge clk) begin
		if (cmd.mark && !hold_zero) begin
			hist_mem[wptr_q] <= pick_q;
		end
		rd_s1 <= hist_mem[rptr_q[HIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			fill_q    <= '0;
			rptr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			rd_use_s1 <= 1'b0;
		end else begin
			if (wipe_hist) begin
				wptr_q <= '0;
				fill_q <= '0;
			end else if (cmd.mark && !hold_zero) begin
				wptr_q <= (wptr_q == hold_m1[HIW-1:0]) ? '0 : wptr_q + HIW'(1);
				if (fill_q != hold_count) begin
					fill_q <= fill_q + HW'(1);
				end
			end
			if (cmd.mark) begin
				rptr_q    <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.refill_step) begin
				rd_vld_s1 <= (rptr_q < hold_count);
				rd_use_s1 <= (rptr_q < fill_q);
				if (rptr_q < hold_count) begin
					rptr_q <= rptr_q + HW'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.mark) begin
			out_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mark) begin
			out_val_q <= DATA_W'(pick_q) + offset;
			out_eos_q <= eos;
		end
	end

	assign rsp_valid   = out_vld_q;
	assign drawn_value = out_val_q;
	assign end_of_set  = out_eos_q;

	`URN_ASSERT_IMP(a_cnt_range, cmd.mul, cnt_q <= set_size)
	`URN_ASSERT_IMP(a_pick_range, cmd.mark, SZW'(pick_q) < set_size)
	`URN_ASSERT_IMP(a_hist_ptrs, !hold_zero, (HW'(wptr_q) < hold_count) && (fill_q <= hold_count))
	`URN_ASSERT_NXT(a_pick_marked, cmd.mark && !eos, used_q[pick_q])

endmodule
